### hdl/sli_pkg.sv
package sli_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_SEEK    = 2'd2,
        OP_ADVANCE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2,
        ST_ORDER     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_RESULT
    } state_t;

    localparam logic REG_LISTS_IN_USE = 1'b0;
    localparam logic [2:0] LISTS_RESET = 3'd2;
    localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

endpackage

### hdl/sli_store.sv
module sli_store #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hdl/sorted_list_intersection_unit.sv
// Clear and load beats, and a seek or advance refused at once, have their result registered at
// the edge that accepts them. Any other seek or advance runs list probes in turn (a store read,
// then one compare that steps a cursor or checks a list), goes to S_RESULT if a cursor is found at
// its list's end, and registers the result once the output slot is free; no beat is taken meanwhile.
// Reset (rst_n low, asynchronous) empties all lists, zeroes cursors and position, clears the
// exhausted flag and sets lists_in_use to 2; the id store itself is not cleared.
module sorted_list_intersection_unit #(
    parameter int MAX_LISTS  = 4,
    parameter int LIST_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  list_index,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] doc_id,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int DW = $clog2(LIST_DEPTH);
    localparam int CW = DW + 1;
    localparam int AW = LW + DW;
    localparam int IW = (LW > 2) ? LW : 2;

    sli_pkg::state_t state_reg, state_next;

    logic [2:0]    lists_in_use_reg;
    logic [CW-1:0] length_reg [MAX_LISTS];
    logic [CW-1:0] length_next [MAX_LISTS];
    logic [CW-1:0] cursor_reg [MAX_LISTS];
    logic [CW-1:0] cursor_next [MAX_LISTS];
    logic [31:0]   last_id_reg [MAX_LISTS];
    logic [31:0]   last_id_next [MAX_LISTS];
    logic [31:0]   pos_reg, pos_next;
    logic          exh_reg, exh_next;
    logic [31:0]   cand_reg, cand_next;
    logic [LW-1:0] list_reg, list_next;
    logic          agreed_reg, agreed_next;
    logic [31:0]   res_doc_reg, res_doc_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   doc_id_reg, doc_id_next;
    logic [1:0]    status_reg, status_next;

    logic          accept;
    logic          cfg_write;
    logic [4:0]    n_lists;
    logic [LW-1:0] last_list;
    logic [IW-1:0] idx_wide;
    logic [LW-1:0] load_sel;
    logic [LW-1:0] sel_list;
    logic [CW-1:0] len_sel;
    logic [CW-1:0] cur_sel;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          slot_free;
    logic          agreed_now;
    logic [31:0]   target;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == sli_pkg::REG_LISTS_IN_USE);
    assign prdata    = (paddr[2] == sli_pkg::REG_LISTS_IN_USE) ? {29'd0, lists_in_use_reg}
                                                                : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_in_use_reg <= sli_pkg::LISTS_RESET;
        end
        else if (cfg_write)
        begin
            lists_in_use_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        n_lists = (lists_in_use_reg < 3'd2) ? 5'd2 : {2'd0, lists_in_use_reg};
        if (n_lists > 5'(MAX_LISTS))
        begin
            n_lists = 5'(MAX_LISTS);
        end
    end

    assign last_list = LW'(n_lists - 5'd1);
    assign idx_wide  = IW'(list_index);
    assign load_sel  = idx_wide[LW-1:0];
    assign sel_list  = (state_reg == sli_pkg::S_IDLE) ? load_sel : list_reg;
    assign len_sel   = length_reg[sel_list];
    assign cur_sel   = cursor_reg[list_reg];
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == sli_pkg::S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign mem_waddr = {load_sel, len_sel[DW-1:0]};
    assign mem_raddr = {list_reg, cur_sel[DW-1:0]};
    assign agreed_now = agreed_reg && !(mem_rdata > cand_reg);

    sli_store #(
        .AW(AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        cursor_next     = cursor_reg;
        last_id_next    = last_id_reg;
        pos_next        = pos_reg;
        exh_next        = exh_reg;
        cand_next       = cand_reg;
        list_next       = list_reg;
        agreed_next     = agreed_reg;
        res_doc_next    = res_doc_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        doc_id_next     = doc_id_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        target          = 32'd0;

        case (state_reg)
            sli_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    doc_id_next = 32'd0;
                    status_next = sli_pkg::ST_OK;
                    case (sli_pkg::opcode_t'(opcode))
                        sli_pkg::OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            for (int i = 0; i < MAX_LISTS; i++)
                            begin
                                length_next[i] = '0;
                                cursor_next[i] = '0;
                            end
                            pos_next = 32'd0;
                            exh_next = 1'b0;
                        end
                        sli_pkg::OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if ({3'd0, list_index} >= 5'(MAX_LISTS))
                            begin
                                status_next = sli_pkg::ST_FULL;
                            end
                            else if (len_sel >= CW'(LIST_DEPTH))
                            begin
                                status_next = sli_pkg::ST_FULL;
                            end
                            else if ((len_sel != '0) && (value <= last_id_reg[load_sel]))
                            begin
                                status_next = sli_pkg::ST_ORDER;
                            end
                            else
                            begin
                                mem_we                 = 1'b1;
                                length_next[load_sel]  = len_sel + CW'(1);
                                last_id_next[load_sel] = value;
                            end
                        end
                        default:
                        begin
                            if (sli_pkg::opcode_t'(opcode) == sli_pkg::OP_SEEK)
                            begin
                                target = (value > pos_reg) ? value : pos_reg;
                            end
                            else
                            begin
                                target = pos_reg + 32'd1;
                            end
                            if (exh_reg || ((sli_pkg::opcode_t'(opcode) == sli_pkg::OP_ADVANCE)
                                            && (pos_reg == sli_pkg::ID_MAX)))
                            begin
                                out_valid_next = 1'b1;
                                status_next    = sli_pkg::ST_EXHAUSTED;
                                exh_next       = 1'b1;
                            end
                            else
                            begin
                                cand_next   = target;
                                list_next   = '0;
                                agreed_next = 1'b1;
                                state_next  = sli_pkg::S_CHECK;
                            end
                        end
                    endcase
                end
            end
            sli_pkg::S_CHECK:
            begin
                if (cur_sel >= len_sel)
                begin
                    exh_next        = 1'b1;
                    res_doc_next    = 32'd0;
                    res_status_next = sli_pkg::ST_EXHAUSTED;
                    state_next      = sli_pkg::S_RESULT;
                end
                else
                begin
                    state_next = sli_pkg::S_CMP;
                end
            end
            sli_pkg::S_CMP:
            begin
                state_next = sli_pkg::S_CHECK;
                if (mem_rdata < cand_reg)
                begin
                    cursor_next[list_reg] = cur_sel + CW'(1);
                end
                else
                begin
                    if (mem_rdata > cand_reg)
                    begin
                        cand_next = mem_rdata;
                    end
                    if (list_reg == last_list)
                    begin
                        if (agreed_now)
                        begin
                            pos_next        = cand_reg;
                            res_doc_next    = cand_reg;
                            res_status_next = sli_pkg::ST_OK;
                            state_next      = sli_pkg::S_RESULT;
                        end
                        else
                        begin
                            list_next   = '0;
                            agreed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        list_next   = list_reg + LW'(1);
                        agreed_next = agreed_now;
                    end
                end
            end
            sli_pkg::S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    doc_id_next    = res_doc_reg;
                    status_next    = res_status_reg;
                    state_next     = sli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sli_pkg::S_IDLE;
            pos_reg       <= 32'd0;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            list_reg      <= '0;
            agreed_reg    <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                length_reg[i] <= '0;
                cursor_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
            list_reg      <= list_next;
            agreed_reg    <= agreed_next;
            length_reg    <= length_next;
            cursor_reg    <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_id_reg    <= last_id_next;
        cand_reg       <= cand_next;
        res_doc_reg    <= res_doc_next;
        res_status_reg <= res_status_next;
        doc_id_reg     <= doc_id_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign doc_id    = doc_id_reg;
    assign status    = status_reg;

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == sli_pkg::ST_EXHAUSTED)) |-> (doc_id_reg == 32'd0))
        else $error("exhausted beat carries a non-zero id");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sli_pkg::S_CMP) |-> (cursor_reg[list_reg] < length_reg[list_reg]))
        else $error("cursor probed beyond the end of its list");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sli_pkg::opcode_t'(opcode) == sli_pkg::OP_CLEAR))
        |=> ((length_reg[0] == '0) && !exh_reg && (pos_reg == 32'd0)))
        else $error("clear did not empty the lists");

    a_found_is_position: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sli_pkg::S_RESULT) && (res_status_reg == sli_pkg::ST_OK))
        |-> (res_doc_reg == pos_reg))
        else $error("found id differs from current position");

    a_exhausted_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (exh_reg && !(accept && (sli_pkg::opcode_t'(opcode) == sli_pkg::OP_CLEAR)))
        |=> exh_reg)
        else $error("exhausted flag dropped without a clear");

endmodule
